// File: hdl/assert_macros.svh
// assertion macros for the checker file of the decimator
// depends on nothing; each use sits on a line of its own
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// condition never seen at a rising edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `ASSERT_CLK(label, clk, rst_n, !(cond), msg)

`endif

// File: hdl/tbad_pkg.sv
// shared types and constants of the time bin average decimator
// no dependencies; imported by every module of the block
package tbad_pkg;

  localparam int IN_TIME_W      = 48;
  localparam int VALUE_W        = 32;
  localparam int OUT_TIME_W     = 48;
  localparam int OUT_COUNT_W    = 16;
  localparam int FLAG_W         = 2;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_W         = 2;
  localparam logic [31:0] BIN_WIDTH_RESET = 32'd1000;

  // one input item
  typedef struct packed {
    logic [IN_TIME_W-1:0]      sample_time;
    logic signed [VALUE_W-1:0] sample_value;
    logic                      last_sample;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic [OUT_TIME_W-1:0]     mean_time;
    logic signed [VALUE_W-1:0] mean_value;
    logic [OUT_COUNT_W-1:0]    bin_samples;
    logic                      count_overflow;
    logic                      final_point;
  } out_item_t;

  // status carried with a closed bin through the queue
  typedef struct packed {
    logic overflow;
    logic final_pt;
  } bin_flags_t;

  // back end sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_HOLD
  } back_state_e;

endpackage

// File: hdl/tbad_front.sv
// front end: bin width register, bin classification and running sums
// depends on tbad_pkg; pushes closed bins into tbad_queue
module tbad_front #(
  parameter int COUNT_BITS = 16,
  parameter int TIME_BITS  = 48,
  localparam int ENTRY_W = TIME_BITS + 3 * COUNT_BITS + tbad_pkg::VALUE_W + tbad_pkg::FLAG_W
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tbad_pkg::in_item_t in_item_i,
  input  logic               room_i,
  output logic               push_a_o,
  output logic [ENTRY_W-1:0] data_a_o,
  output logic               push_b_o,
  output logic [ENTRY_W-1:0] data_b_o
);
  import tbad_pkg::*;

  localparam int TSW = TIME_BITS + COUNT_BITS;
  localparam int VSW = VALUE_W + COUNT_BITS;

  logic [31:0]            width_q;
  logic                   open_q, open_d;
  logic [TIME_BITS:0]     start_q, start_d;
  logic [TSW-1:0]         tsum_q, tsum_d, u_tsum;
  logic signed [VSW-1:0]  vsum_q, vsum_d, u_vsum;
  logic [COUNT_BITS-1:0]  cnt_q, cnt_d, u_cnt;
  logic                   ovf_q, ovf_d, u_ovf;
  logic [TIME_BITS:0]     u_start;

  logic [TIME_BITS+IN_TIME_W-1:0] t_wide;
  logic [TIME_BITS-1:0]   t;
  logic signed [VSW-1:0]  v;
  logic [TIME_BITS+1:0]   bin_end;
  logic                   join_bin, close_bin, accept;
  bin_flags_t             cur_flags, upd_flags;
  logic [ENTRY_W-1:0]     cur_entry, upd_entry;

  // bin width register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= BIN_WIDTH_RESET;
    end else if (cfg_we_i) begin
      width_q <= cfg_wdata_i;
    end
  end

  // sample fields at internal widths
  assign t_wide = {{TIME_BITS{1'b0}}, in_item_i.sample_time};
  assign t      = t_wide[TIME_BITS-1:0];
  assign v      = {{COUNT_BITS{in_item_i.sample_value[VALUE_W-1]}}, in_item_i.sample_value};

  // bin end, also the next bin start when the bin closes
  assign bin_end   = {1'b0, start_q} + {{(TIME_BITS + 2 - 32){1'b0}}, width_q};
  assign join_bin  = open_q && ({2'b00, t} < bin_end);
  assign close_bin = open_q && !join_bin;

  assign in_ready_o = room_i;
  assign accept     = in_valid_i && room_i;

  // bin state after this sample, before a flush
  always_comb begin
    u_tsum  = tsum_q;
    u_vsum  = vsum_q;
    u_cnt   = cnt_q;
    u_ovf   = ovf_q;
    u_start = start_q;
    if (!join_bin) begin
      u_tsum  = {{COUNT_BITS{1'b0}}, t};
      u_vsum  = v;
      u_cnt   = COUNT_BITS'(1);
      u_ovf   = 1'b0;
      u_start = open_q ? bin_end[TIME_BITS:0] : {1'b0, t};
    end else if (cnt_q == {COUNT_BITS{1'b1}}) begin
      u_ovf = 1'b1;
    end else begin
      u_tsum = tsum_q + {{COUNT_BITS{1'b0}}, t};
      u_vsum = vsum_q + v;
      u_cnt  = cnt_q + COUNT_BITS'(1);
    end
  end

  // closed bin snapshots
  assign cur_flags = '{overflow: ovf_q, final_pt: 1'b0};
  assign upd_flags = '{overflow: u_ovf, final_pt: 1'b1};
  assign cur_entry = {tsum_q, vsum_q, cnt_q, cur_flags};
  assign upd_entry = {u_tsum, u_vsum, u_cnt, upd_flags};

  assign push_a_o = accept && (close_bin || in_item_i.last_sample);
  assign data_a_o = close_bin ? cur_entry : upd_entry;
  assign push_b_o = accept && close_bin && in_item_i.last_sample;
  assign data_b_o = upd_entry;

  // next bin state, last sample returns to the empty stream
  always_comb begin
    open_d  = open_q;
    start_d = start_q;
    tsum_d  = tsum_q;
    vsum_d  = vsum_q;
    cnt_d   = cnt_q;
    ovf_d   = ovf_q;
    if (accept) begin
      if (in_item_i.last_sample) begin
        open_d  = 1'b0;
        start_d = '0;
        tsum_d  = '0;
        vsum_d  = '0;
        cnt_d   = '0;
        ovf_d   = 1'b0;
      end else begin
        open_d  = 1'b1;
        start_d = u_start;
        tsum_d  = u_tsum;
        vsum_d  = u_vsum;
        cnt_d   = u_cnt;
        ovf_d   = u_ovf;
      end
    end
  end

  // bin state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= 1'b0;
      start_q <= '0;
      tsum_q  <= '0;
      vsum_q  <= '0;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      open_q  <= open_d;
      start_q <= start_d;
      tsum_q  <= tsum_d;
      vsum_q  <= vsum_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

// File: hdl/tbad_queue.sv
// short queue of closed bins between front and back end
// depends on tbad_pkg; takes up to two entries and gives one per cycle when popped
module tbad_queue #(
  parameter int ENTRY_W = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_a_i,
  input  logic [ENTRY_W-1:0] data_a_i,
  input  logic               push_b_i,
  input  logic [ENTRY_W-1:0] data_b_i,
  output logic               room_o,
  output logic               valid_o,
  output logic [ENTRY_W-1:0] data_o,
  input  logic               pop_i
);
  import tbad_pkg::*;

  localparam logic [QPTR_W:0] ROOM_LIMIT = (QPTR_W + 1)'(QUEUE_DEPTH - 2);

  logic [ENTRY_W-1:0] entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]    fill_q, fill_d;
  logic [QPTR_W:0]    n_push;
  logic [QPTR_W-1:0]  wr_ptr_b;

  assign n_push   = (QPTR_W + 1)'(push_a_i) + (QPTR_W + 1)'(push_b_i);
  assign wr_ptr_b = wr_ptr_q + QPTR_W'(1);
  assign room_o   = (fill_q <= ROOM_LIMIT);
  assign valid_o  = (fill_q != '0);
  assign data_o   = entries_q[rd_ptr_q];

  // pointer and fill update
  always_comb begin
    wr_ptr_d = wr_ptr_q + n_push[QPTR_W-1:0];
    rd_ptr_d = rd_ptr_q + QPTR_W'(pop_i);
    fill_d   = fill_q + n_push - (QPTR_W + 1)'(pop_i);
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_a_i) begin
      entries_q[wr_ptr_q] <= data_a_i;
    end
    if (push_b_i) begin
      entries_q[wr_ptr_b] <= data_b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

endmodule

// File: hdl/tbad_back.sv
// back end: bit-serial mean division of a closed bin and output register
// depends on tbad_pkg; pops entries from tbad_queue
module tbad_back #(
  parameter int COUNT_BITS = 16,
  parameter int TIME_BITS  = 48,
  localparam int ENTRY_W = TIME_BITS + 3 * COUNT_BITS + tbad_pkg::VALUE_W + tbad_pkg::FLAG_W
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  logic [ENTRY_W-1:0]  q_data_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tbad_pkg::out_item_t out_item_o
);
  import tbad_pkg::*;

  localparam int DW     = TIME_BITS + COUNT_BITS;
  localparam int VSW    = VALUE_W + COUNT_BITS;
  localparam int STEP_W = $clog2(DW + 1);

  // queue entry fields
  logic [DW-1:0]         e_tsum;
  logic [VSW-1:0]        e_vsum;
  logic [COUNT_BITS-1:0] e_cnt;
  bin_flags_t            e_flags;
  logic [VSW-1:0]        e_mag;
  logic [DW+VSW-1:0]     e_mag_wide;

  back_state_e           state_q, state_d;
  logic                  load, step_en, out_load;

  logic [DW-1:0]         tq_q, vq_q;
  logic [COUNT_BITS-1:0] trem_q, vrem_q, div_q;
  logic                  neg_q;
  bin_flags_t            flags_q;
  logic [STEP_W-1:0]     step_q;

  logic [COUNT_BITS:0]   tr_sh, vr_sh, tr_diff, vr_diff;
  logic                  t_ge, v_ge;
  logic [COUNT_BITS-1:0] trem_nx, vrem_nx;

  logic [OUT_TIME_W+DW-1:0]          mt_wide;
  logic [OUT_COUNT_W+COUNT_BITS-1:0] bs_wide;
  logic [VALUE_W-1:0]                vq_lo, mv;
  out_item_t                         out_q;
  logic                              out_valid_q;

  assign {e_tsum, e_vsum, e_cnt, e_flags} = q_data_i;

  // value magnitude, divided unsigned and signed again at the end
  assign e_mag      = e_vsum[VSW-1] ? (VSW'(0) - e_vsum) : e_vsum;
  assign e_mag_wide = {{DW{1'b0}}, e_mag};

  // one restoring step per cycle on both lanes
  assign tr_sh   = {trem_q, tq_q[DW-1]};
  assign vr_sh   = {vrem_q, vq_q[DW-1]};
  assign tr_diff = tr_sh - {1'b0, div_q};
  assign vr_diff = vr_sh - {1'b0, div_q};
  assign t_ge    = (tr_sh >= {1'b0, div_q});
  assign v_ge    = (vr_sh >= {1'b0, div_q});
  assign trem_nx = t_ge ? tr_diff[COUNT_BITS-1:0] : tr_sh[COUNT_BITS-1:0];
  assign vrem_nx = v_ge ? vr_diff[COUNT_BITS-1:0] : vr_sh[COUNT_BITS-1:0];

  // sequencer: fetch, divide, hand over to the output register
  always_comb begin
    state_d  = state_q;
    load     = 1'b0;
    step_en  = 1'b0;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          load    = 1'b1;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        step_en = 1'b1;
        if (step_q == STEP_W'(1)) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign q_pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // divider datapath
  always_ff @(posedge clk_i) begin
    if (load) begin
      tq_q    <= e_tsum;
      vq_q    <= e_mag_wide[DW-1:0];
      trem_q  <= '0;
      vrem_q  <= '0;
      div_q   <= e_cnt;
      neg_q   <= e_vsum[VSW-1];
      flags_q <= e_flags;
      step_q  <= STEP_W'(DW);
    end else if (step_en) begin
      tq_q   <= {tq_q[DW-2:0], t_ge};
      vq_q   <= {vq_q[DW-2:0], v_ge};
      trem_q <= trem_nx;
      vrem_q <= vrem_nx;
      step_q <= step_q - STEP_W'(1);
    end
  end

  // result fields at port widths
  assign mt_wide = {{OUT_TIME_W{1'b0}}, tq_q};
  assign bs_wide = {{OUT_COUNT_W{1'b0}}, div_q};
  assign vq_lo   = vq_q[VALUE_W-1:0];
  assign mv      = neg_q ? (VALUE_W'(0) - vq_lo) : vq_lo;

  // output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.mean_time      <= mt_wide[OUT_TIME_W-1:0];
      out_q.mean_value     <= $signed(mv);
      out_q.bin_samples    <= bs_wide[OUT_COUNT_W-1:0];
      out_q.count_overflow <= flags_q.overflow;
      out_q.final_point    <= flags_q.final_pt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: hdl/time_bin_average_decimator.sv
// a closed bin passes through the bin queue, the bit-serial divider and the output register
// before it shows at the output
// throughput: items are taken each cycle while the four-entry bin queue has room for two;
// results leave one at a time: the back end fetches the next bin only after the last is handed on
// reset: bin state, queue pointers and output valid clear at once, bin_width returns to 1000
module time_bin_average_decimator #(
  parameter int COUNT_BITS = 16,
  parameter int TIME_BITS  = 48
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tbad_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tbad_pkg::out_item_t out_item_o
);
  import tbad_pkg::*;

  localparam int ENTRY_W = TIME_BITS + 3 * COUNT_BITS + VALUE_W + FLAG_W;

  logic               room, push_a, push_b, q_valid, q_pop;
  logic [ENTRY_W-1:0] data_a, data_b, q_data;

  // sample classification and accumulation
  tbad_front #(
    .COUNT_BITS(COUNT_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .room_i     (room),
    .push_a_o   (push_a),
    .data_a_o   (data_a),
    .push_b_o   (push_b),
    .data_b_o   (data_b)
  );

  // closed bins waiting for the divider
  tbad_queue #(
    .ENTRY_W(ENTRY_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_a_i(push_a),
    .data_a_i(data_a),
    .push_b_i(push_b),
    .data_b_i(data_b),
    .room_o  (room),
    .valid_o (q_valid),
    .data_o  (q_data),
    .pop_i   (q_pop)
  );

  // mean computation and output
  tbad_back #(
    .COUNT_BITS(COUNT_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_data_i   (q_data),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

endmodule

// File: hdl/tbad_checker.sv
// port-level checks of the decimator output, bound to the top level
// depends on tbad_pkg and assert_macros.svh
`include "assert_macros.svh"

module tbad_checker #(
  parameter int COUNT_BITS = 16
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input tbad_pkg::out_item_t out_item_o
);
  import tbad_pkg::*;

  localparam logic [OUT_COUNT_W+COUNT_BITS-1:0] FULL_WIDE = {{OUT_COUNT_W{1'b0}},
                                                             {COUNT_BITS{1'b1}}};
  localparam logic [OUT_COUNT_W-1:0] FULL_COUNT = FULL_WIDE[OUT_COUNT_W-1:0];

  // stalled item stays
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o, "output item dropped while stalled")
  `ASSERT_CLK(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i |=> $stable(out_item_o), "output item changed while stalled")

  // a saturated bin reports the full count
  `ASSERT_CLK(a_ovf_full, clk_i, rst_ni, out_valid_o && out_item_o.count_overflow |-> out_item_o.bin_samples == FULL_COUNT, "overflow flagged on a bin that is not full")

  // a single sample bin cannot have dropped samples
  `ASSERT_NEVER(a_one_no_ovf, clk_i, rst_ni, out_valid_o && out_item_o.bin_samples == OUT_COUNT_W'(1) && out_item_o.count_overflow, "overflow flagged on a one sample bin")

endmodule

bind time_bin_average_decimator tbad_checker #(.COUNT_BITS(COUNT_BITS)) u_tbad_checker (.*);
